// ===== src/flpa_pkg.sv =====
// Shared types, codes and constants for the free list pool allocator.
package flpa_pkg;

    localparam int POOL_SIZE = 256;
    localparam int SLOT_W    = 8;
    localparam int CAP_W     = 9;
    localparam int NB_W      = 16;
    localparam int OFS_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CAP_W-1:0] POOL_CAP = CAP_W'(POOL_SIZE);

    localparam logic FUNC_RESERVE = 1'b0;
    localparam logic FUNC_FREE    = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_BYTES       = 2'd1;

    localparam logic [CAP_W-1:0] RESET_CAPACITY = 9'd16;
    localparam logic [NB_W-1:0]  RESET_NODE_BYTES = 16'd16;

    typedef enum logic [1:0] {
        ST_GRANTED   = 2'd0,
        ST_FREED     = 2'd1,
        ST_EXHAUSTED = 2'd2
    } status_t;

    typedef enum logic {
        CTL_IDLE = 1'b0,
        CTL_LINK = 1'b1
    } ctl_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;     // request taken this cycle
        logic list_pop;   // reserve served from the free list
        logic take_link;  // load the new head from the link read
        logic a_move;     // result stage moves into the output register
    } flpa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic free_valid;
        logic a_valid;
        logic m_valid;
    } flpa_stat_t;

endpackage

// ===== src/flpa_ctrl.sv =====
// Controller: request handshake and the wait for the free list link read.
module flpa_ctrl import flpa_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_func,
    input  logic       m_ready,
    input  flpa_stat_t stat,
    output logic       s_ready,
    output flpa_cmd_t  cmd
);

    ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CTL_IDLE: begin
                if (cmd.list_pop) begin
                    state_next = CTL_LINK;
                end
            end
            CTL_LINK: state_next = CTL_IDLE;
            default:  state_next = CTL_IDLE;
        endcase
    end

    always_comb begin
        cmd.a_move    = stat.a_valid && (!stat.m_valid || m_ready);
        s_ready       = 1'b0;
        cmd.take_link = 1'b0;
        case (state_reg)
            CTL_IDLE: s_ready       = !stat.a_valid || cmd.a_move;
            CTL_LINK: cmd.take_link = 1'b1;
            default: begin
                s_ready       = 1'b0;
                cmd.take_link = 1'b0;
            end
        endcase
        cmd.accept   = s_valid && s_ready;
        cmd.list_pop = cmd.accept && (s_func == FUNC_RESERVE) && stat.free_valid;
    end

    a_link_follows_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take_link |-> $past(cmd.list_pop))
        else $error("link load without a preceding free list pop");

    a_no_accept_in_link: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take_link |-> !cmd.accept)
        else $error("request accepted while the head is being reloaded");

    a_ready_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!stat.a_valid || cmd.a_move))
        else $error("ready raised with the result stage blocked");

endmodule

// ===== src/flpa_dp.sv =====
// Datapath: free list head, link memory, fresh watermark, capacity and result stages.
module flpa_dp import flpa_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  flpa_cmd_t            cmd,
    input  logic                 s_func,
    input  logic [SLOT_W-1:0]    s_slot,
    input  logic                 m_ready,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output flpa_stat_t           stat,
    output logic                 m_valid,
    output logic [1:0]           m_status,
    output logic [SLOT_W-1:0]    m_granted_slot,
    output logic [OFS_W-1:0]     m_byte_offset,
    output logic [CAP_W-1:0]     m_capacity_now
);

    function automatic logic [CAP_W-1:0] start_capacity(input logic [CAP_W-1:0] c);
        logic [CAP_W-1:0] r;
        r = c;
        if (c == '0) begin
            r = CAP_W'(1);
        end else if (c > POOL_CAP) begin
            r = POOL_CAP;
        end
        return r;
    endfunction

    // link entry: {next valid, next slot}
    logic [SLOT_W:0] link_mem [POOL_SIZE];
    logic [SLOT_W:0] link_rd_reg;

    logic [SLOT_W-1:0] head_reg, head_next;
    logic              free_valid_reg, free_valid_next;
    logic [CAP_W-1:0]  fresh_reg, fresh_next;
    logic [CAP_W-1:0]  enabled_reg, enabled_next;
    logic [NB_W-1:0]   node_bytes_reg;

    logic              a_valid_reg;
    status_t           a_status_reg, a_status_next;
    logic [SLOT_W-1:0] a_granted_reg, a_granted_next;
    logic [CAP_W-1:0]  a_cap_reg;

    logic              m_valid_reg;
    status_t           m_status_reg;
    logic [SLOT_W-1:0] m_granted_reg;
    logic [OFS_W-1:0]  m_offset_reg;
    logic [CAP_W-1:0]  m_cap_reg;

    logic             link_we;
    logic [CAP_W:0]   inc_sum;
    logic [CAP_W:0]   grown_sum;
    logic [CAP_W-1:0] grown;
    logic [CAP_W-1:0] cap_work;

    assign link_we = cmd.accept && (s_func == FUNC_FREE) && ({1'b0, s_slot} < fresh_reg);

    always_comb begin
        inc_sum   = {1'b0, enabled_reg} + (CAP_W+1)'(1);
        grown_sum = {1'b0, enabled_reg} + (inc_sum >> 1);
        grown     = (grown_sum > {1'b0, POOL_CAP}) ? POOL_CAP : grown_sum[CAP_W-1:0];
    end

    always_comb begin
        head_next       = head_reg;
        free_valid_next = free_valid_reg;
        fresh_next      = fresh_reg;
        enabled_next    = enabled_reg;
        a_status_next   = ST_FREED;
        a_granted_next  = '0;
        cap_work        = enabled_reg;
        if (cmd.take_link) begin
            head_next       = link_rd_reg[SLOT_W-1:0];
            free_valid_next = link_rd_reg[SLOT_W];
        end else if (cmd.accept) begin
            if (s_func == FUNC_FREE) begin
                if (link_we) begin
                    head_next       = s_slot;
                    free_valid_next = 1'b1;
                end
            end else if (free_valid_reg) begin
                a_status_next  = ST_GRANTED;
                a_granted_next = head_reg;
            end else begin
                // grow once the watermark reaches the enabled capacity
                if ((fresh_reg >= enabled_reg) && (enabled_reg != POOL_CAP)) begin
                    cap_work = grown;
                end
                enabled_next = cap_work;
                if (fresh_reg < cap_work) begin
                    a_status_next  = ST_GRANTED;
                    a_granted_next = fresh_reg[SLOT_W-1:0];
                    fresh_next     = fresh_reg + CAP_W'(1);
                end else begin
                    a_status_next = ST_EXHAUSTED;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[s_slot] <= {free_valid_reg, head_reg};
        end else if (cmd.list_pop) begin
            // drop the link of the slot being handed out
            link_mem[head_reg] <= '0;
        end
        if (cmd.list_pop) begin
            link_rd_reg <= link_mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg       <= '0;
            free_valid_reg <= 1'b0;
            fresh_reg      <= '0;
            enabled_reg    <= RESET_CAPACITY;
            node_bytes_reg <= RESET_NODE_BYTES;
        end else if (cfg_wr_en && (cfg_index == CFG_INITIAL_CAPACITY)) begin
            // reinitialize the pool
            free_valid_reg <= 1'b0;
            fresh_reg      <= '0;
            enabled_reg    <= start_capacity(cfg_data[CAP_W-1:0]);
        end else begin
            head_reg       <= head_next;
            free_valid_reg <= free_valid_next;
            fresh_reg      <= fresh_next;
            enabled_reg    <= enabled_next;
            if (cfg_wr_en && (cfg_index == CFG_NODE_BYTES)) begin
                node_bytes_reg <= cfg_data[NB_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                a_valid_reg <= 1'b1;
            end else if (cmd.a_move) begin
                a_valid_reg <= 1'b0;
            end
            if (cmd.a_move) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            a_status_reg  <= a_status_next;
            a_granted_reg <= a_granted_next;
            a_cap_reg     <= enabled_next;
        end
        if (cmd.a_move) begin
            m_status_reg  <= a_status_reg;
            m_granted_reg <= a_granted_reg;
            // granted is zero for frees and exhausted answers, so the product is too
            m_offset_reg  <= OFS_W'(a_granted_reg * node_bytes_reg);
            m_cap_reg     <= a_cap_reg;
        end
    end

    assign stat.free_valid = free_valid_reg;
    assign stat.a_valid    = a_valid_reg;
    assign stat.m_valid    = m_valid_reg;

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_granted_slot = m_granted_reg;
    assign m_byte_offset  = m_offset_reg;
    assign m_capacity_now = m_cap_reg;

    a_fresh_within_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_reg <= enabled_reg)
        else $error("fresh watermark above enabled capacity");

    a_cap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (enabled_reg != '0) && (enabled_reg <= POOL_CAP))
        else $error("enabled capacity out of range");

    a_nongrant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != ST_GRANTED)) |->
            ((m_granted_reg == '0) && (m_offset_reg == '0)))
        else $error("non-grant result carries a slot or offset");

endmodule

// ===== src/free_list_pool_allocator.sv =====
// Top level of the free list pool allocator: controller plus datapath.
// Hands out slots of a 256-entry pool, reusing freed slots last-in first-out,
// then never-used slots in ascending order, growing the enabled capacity by
// half (rounded up) when it runs out. A reserve served from the free list
// keeps the block busy in the link state while the registered read of the link
// memory yields the new list head; frees, fresh reserves and exhausted
// answers do not. Each result passes through the result stage, then the
// slot times node bytes product register, and the next request can be
// accepted while a result waits on m_ready. The link memory needs no
// clearing after reset. Write configuration only while no request is in
// flight; writing initial_capacity empties the pool.
module free_list_pool_allocator import flpa_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_func,
    input  logic [SLOT_W-1:0]    s_slot,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [SLOT_W-1:0]    m_granted_slot,
    output logic [OFS_W-1:0]     m_byte_offset,
    output logic [CAP_W-1:0]     m_capacity_now
);

    flpa_cmd_t  cmd;
    flpa_stat_t stat;

    flpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .m_ready (m_ready),
        .stat    (stat),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    flpa_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_func         (s_func),
        .s_slot         (s_slot),
        .m_ready        (m_ready),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .stat           (stat),
        .m_valid        (m_valid),
        .m_status       (m_status),
        .m_granted_slot (m_granted_slot),
        .m_byte_offset  (m_byte_offset),
        .m_capacity_now (m_capacity_now)
    );

endmodule

// ===== tb/sv/free_list_pool_allocator_tb.sv =====
// Self-checking testbench for the free list pool allocator: random and directed requests.
module free_list_pool_allocator_tb;
    import flpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [OFS_W-1:0]   offset;
        logic [CAP_W-1:0]   cap;
    } grant_t;

    class pool_scoreboard;
        logic [CAP_W-1:0] init_cap;
        logic [NB_W-1:0]  node_bytes;
        int               list_head;
        bit               list_nonempty;
        int               link_next [POOL_SIZE];
        bit               link_ok [POOL_SIZE];
        int               next_fresh;
        int               enabled;
        grant_t           pending_grants [$];
        int               live_slots [$];
        int               errors;

        function new();
            init_cap   = RESET_CAPACITY;
            node_bytes = RESET_NODE_BYTES;
            errors     = 0;
            reinit();
        endfunction

        function void reinit();
            list_head     = 0;
            list_nonempty = 1'b0;
            foreach (link_next[i]) begin
                link_next[i] = 0;
                link_ok[i]   = 1'b0;
            end
            next_fresh = 0;
            if (init_cap == '0)
                enabled = 1;
            else if (int'(init_cap) > POOL_SIZE)
                enabled = POOL_SIZE;
            else
                enabled = int'(init_cap);
            live_slots.delete();
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_INITIAL_CAPACITY: begin
                    init_cap = data[CAP_W-1:0];
                    reinit();
                end
                CFG_NODE_BYTES: begin
                    node_bytes = data[NB_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function void note_request(logic func, logic [SLOT_W-1:0] slot);
            grant_t     g;
            int         s;
            int         granted;
            int         grown;
            int         pos;
            logic [47:0] prod;
            s        = int'(slot);
            granted  = 0;
            pos      = -1;
            g.status = ST_GRANTED;
            if (func == FUNC_FREE) begin
                g.status = ST_FREED;
                // slots never handed out are dropped without touching the list
                if (s < next_fresh) begin
                    link_next[s]  = list_head;
                    link_ok[s]    = list_nonempty;
                    list_head     = s;
                    list_nonempty = 1'b1;
                    for (int i = 0; i < live_slots.size(); i++)
                        if (live_slots[i] == s && pos < 0)
                            pos = i;
                    if (pos >= 0)
                        live_slots.delete(pos);
                end
            end else if (list_nonempty) begin
                granted            = list_head;
                list_nonempty      = link_ok[granted];
                list_head          = link_next[granted];
                link_ok[granted]   = 1'b0;
                link_next[granted] = 0;
            end else begin
                if (next_fresh >= enabled && enabled < POOL_SIZE) begin
                    grown   = enabled + ((enabled + 1) >> 1);
                    enabled = (grown > POOL_SIZE) ? POOL_SIZE : grown;
                end
                if (next_fresh < enabled) begin
                    granted    = next_fresh;
                    next_fresh = next_fresh + 1;
                end else begin
                    g.status = ST_EXHAUSTED;
                end
            end
            if (g.status == ST_GRANTED) begin
                live_slots.push_back(granted);
                prod     = 48'(granted) * 48'(node_bytes);
                g.offset = prod[OFS_W-1:0];
                g.slot   = SLOT_W'(granted);
            end else begin
                g.offset = '0;
                g.slot   = '0;
            end
            g.cap = CAP_W'(enabled);
            pending_grants.push_back(g);
        endfunction

        function void check_result(logic [1:0] status, logic [SLOT_W-1:0] slot,
                                   logic [OFS_W-1:0] offset, logic [CAP_W-1:0] cap);
            grant_t want;
            if (pending_grants.size() == 0) begin
                $display("%0t: unexpected result, status %0d slot %0d", $time, status, slot);
                errors++;
                return;
            end
            want = pending_grants.pop_front();
            if (status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                errors++;
            end
            if (slot !== want.slot) begin
                $display("%0t: granted_slot expected %0d actual %0d", $time, want.slot, slot);
                errors++;
            end
            if (offset !== want.offset) begin
                $display("%0t: byte_offset expected %0d actual %0d", $time, want.offset, offset);
                errors++;
            end
            if (cap !== want.cap) begin
                $display("%0t: capacity_now expected %0d actual %0d", $time, want.cap, cap);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_func;
    logic [SLOT_W-1:0]    s_slot;
    logic                 m_valid;
    logic                 m_ready;
    logic [1:0]           m_status;
    logic [SLOT_W-1:0]    m_granted_slot;
    logic [OFS_W-1:0]     m_byte_offset;
    logic [CAP_W-1:0]     m_capacity_now;

    pool_scoreboard sb;
    int             idle_pct;
    int             stall_pct;
    int             hold_off_count;

    free_list_pool_allocator DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_slot         (s_slot),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_granted_slot (m_granted_slot),
        .m_byte_offset  (m_byte_offset),
        .m_capacity_now (m_capacity_now)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // outputs are stable at the falling edge; a handshake seen here completes at the next rise
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_status, m_granted_slot, m_byte_offset, m_capacity_now);
    end

    initial begin : receiver
        int served;
        int held;
        served  = 0;
        held    = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_count != served) begin
                served = hold_off_count;
                held   = HOLD_CYCLES;
            end
            if (!aresetn || held != 0) begin
                m_ready <= 1'b0;
                if (held != 0)
                    held--;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        #3_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic send_request(input logic func, input logic [SLOT_W-1:0] slot);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func  <= func;
        s_slot  <= slot;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        sb.note_request(func, slot);
    endtask

    task automatic send_random(input int count, input int free_pct, input int stray_pct);
        int pick;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < free_pct && sb.live_slots.size() != 0) begin
                pick = $urandom_range(sb.live_slots.size() - 1);
                send_request(FUNC_FREE, SLOT_W'(sb.live_slots[pick]));
            end else if ($urandom_range(99) < stray_pct) begin
                // double free or a slot never handed out
                send_request(FUNC_FREE, SLOT_W'($urandom_range(255)));
            end else begin
                send_request(FUNC_RESERVE, SLOT_W'($urandom_range(255)));
            end
        end
    endtask

    // hold until every request has produced its result
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_grants.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_register(idx, data);
    endtask

    initial begin : stimulus
        sb             = new();
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_func         = FUNC_RESERVE;
        s_slot         = '0;
        idle_pct       = 0;
        stall_pct      = 0;
        hold_off_count = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fresh slots, then list reuse in last-in first-out order
        send_request(FUNC_RESERVE, 8'h00);
        send_request(FUNC_RESERVE, 8'hFF);
        send_request(FUNC_RESERVE, 8'hAA);
        send_request(FUNC_FREE, 8'd1);
        send_request(FUNC_FREE, 8'd2);
        send_request(FUNC_RESERVE, 8'h55);
        send_request(FUNC_RESERVE, 8'h00);
        send_request(FUNC_RESERVE, 8'h00);
        // frees of slots never handed out, then a double free
        send_request(FUNC_FREE, 8'd255);
        send_request(FUNC_FREE, 8'd4);
        send_request(FUNC_FREE, 8'd0);
        send_request(FUNC_FREE, 8'd0);
        send_request(FUNC_RESERVE, 8'h00);
        send_request(FUNC_RESERVE, 8'h00);
        send_request(FUNC_RESERVE, 8'h00);
        drain();

        // zero capacity counts as one, then grows by half rounded up
        write_reg(CFG_NODE_BYTES, 16'hFFFF);
        write_reg(CFG_INITIAL_CAPACITY, 16'd0);
        repeat (6) send_request(FUNC_RESERVE, 8'h00);
        send_request(FUNC_FREE, 8'd5);
        send_request(FUNC_RESERVE, 8'h00);
        drain();
        write_reg(CFG_SPARE_A, 16'hFFFF);
        write_reg(CFG_SPARE_B, 16'h0000);
        send_request(FUNC_RESERVE, 8'h00);
        drain();

        // reserve-heavy from capacity one up to an exhausted pool
        write_reg(CFG_INITIAL_CAPACITY, 16'd0);
        idle_pct = 70;
        send_random(360, 8, 2);
        drain();

        // new node size only, allocation state carries over
        write_reg(CFG_NODE_BYTES, CFG_DAT_W'($urandom_range(1, 65535)));
        idle_pct  = 0;
        stall_pct = 70;
        send_random(350, 45, 3);
        drain();

        write_reg(CFG_INITIAL_CAPACITY, 16'd256);
        write_reg(CFG_NODE_BYTES, 16'h0000);
        idle_pct  = 20;
        stall_pct = 20;
        send_random(400, 40, 3);
        drain();

        // capacity above the pool size saturates; receiver holds off to back up the block
        write_reg(CFG_INITIAL_CAPACITY, 16'd511);
        write_reg(CFG_NODE_BYTES, 16'd1);
        idle_pct  = 0;
        stall_pct = 0;
        send_random(20, 30, 2);
        hold_off_count = hold_off_count + 1;
        send_random(230, 30, 2);
        drain();

        write_reg(CFG_INITIAL_CAPACITY, CFG_DAT_W'($urandom_range(2, 40)));
        write_reg(CFG_NODE_BYTES, CFG_DAT_W'($urandom_range(1, 65535)));
        idle_pct = 70;
        send_random(350, 35, 3);
        drain();

        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_grants.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
